/* rtl/core/hrhp_pkg.sv */
// Package for the HTTP request head parser: parse positions, verdict and
// byte-kind codes, character class helpers and the per-beat record types.
// No dependencies.
package hrhp_pkg;

    typedef enum logic [4:0] {
        POS_METHOD_START = 5'd0,
        POS_METHOD       = 5'd1,
        POS_URI          = 5'd2,
        POS_VER_H        = 5'd3,
        POS_VER_T1       = 5'd4,
        POS_VER_T2       = 5'd5,
        POS_VER_P        = 5'd6,
        POS_VER_SLASH    = 5'd7,
        POS_MAJOR_START  = 5'd8,
        POS_MAJOR        = 5'd9,
        POS_MINOR_START  = 5'd10,
        POS_MINOR        = 5'd11,
        POS_NL1          = 5'd12,
        POS_LINE_START   = 5'd13,
        POS_LWS          = 5'd14,
        POS_NAME         = 5'd15,
        POS_SPACE_VALUE  = 5'd16,
        POS_VALUE        = 5'd17,
        POS_NL2          = 5'd18,
        POS_NL3          = 5'd19,
        POS_BAD          = 5'd20,
        POS_GOOD         = 5'd21
    } t_pos;

    localparam logic [1:0] VERDICT_MORE = 2'd0;
    localparam logic [1:0] VERDICT_GOOD = 2'd1;
    localparam logic [1:0] VERDICT_BAD  = 2'd2;

    localparam logic [2:0] KIND_NONE     = 3'd0;
    localparam logic [2:0] KIND_METHOD   = 3'd1;
    localparam logic [2:0] KIND_URI      = 3'd2;
    localparam logic [2:0] KIND_NEW_NAME = 3'd3;
    localparam logic [2:0] KIND_NAME     = 3'd4;
    localparam logic [2:0] KIND_VALUE    = 3'd5;

    localparam logic [7:0] CH_DEL   = 8'd127;
    localparam logic [7:0] CH_CTL   = 8'd31;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] V_MAX    = 8'd255;

    // Parser state carried from beat to beat
    typedef struct packed {
        t_pos       pos;
        logic       hdr_started;
        logic [7:0] major;
        logic [7:0] minor;
    } t_state;

    // Per-beat result
    typedef struct packed {
        logic [1:0] verdict;
        logic [2:0] kind;
        logic [7:0] data;
    } t_result;

    function automatic logic is_control(input logic [7:0] c);
        return (c <= CH_CTL) || (c == CH_DEL);
    endfunction

    function automatic logic is_dec(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_separator(input logic [7:0] c);
        logic sep;
        case (c) inside
            8'h28, 8'h29, 8'h3C, 8'h3E, 8'h40, 8'h2C, 8'h3B, 8'h3A, 8'h5C, 8'h22,
            8'h2F, 8'h5B, 8'h5D, 8'h3F, 8'h3D, 8'h7B, 8'h7D, 8'h20, 8'h09:
                sep = 1'b1;
            default: sep = 1'b0;
        endcase
        return sep;
    endfunction

    function automatic logic is_token(input logic [7:0] c);
        return !c[7] && !is_control(c) && !is_separator(c);
    endfunction

    // Append one decimal digit, saturate at 255
    function automatic logic [7:0] add_digit(input logic [7:0] v, input logic [7:0] c);
        logic [11:0] n;
        n = 12'({v, 3'b000}) + 12'({v, 1'b0}) + 12'(c - CH_ZERO);
        return (n > 12'(V_MAX)) ? V_MAX : n[7:0];
    endfunction

endpackage

/* rtl/core/hrhp_step.sv */
// Per-beat transition logic of the HTTP request head parser.
// Depends on hrhp_pkg.
module hrhp_step (
    input  hrhp_pkg::t_state  i_state,
    input  logic              i_restart,
    input  logic [7:0]        i_byte,
    output hrhp_pkg::t_state  o_state,
    output hrhp_pkg::t_result o_result
);
    import hrhp_pkg::*;

    logic [7:0] c;
    t_pos       n_pos;
    logic       n_hdr;
    logic [7:0] n_major;
    logic [7:0] n_minor;
    logic [2:0] kind;
    logic [1:0] verdict;

    assign c = i_byte;

    // Next position and side state
    always_comb begin
        n_pos   = i_state.pos;
        n_hdr   = i_state.hdr_started;
        n_major = i_state.major;
        n_minor = i_state.minor;
        if (i_restart) begin
            n_pos   = POS_METHOD_START;
            n_hdr   = 1'b0;
            n_major = '0;
            n_minor = '0;
        end else begin
            unique case (i_state.pos)
                POS_METHOD_START: n_pos = is_token(c) ? POS_METHOD : POS_BAD;
                POS_METHOD: begin
                    if (c == CH_SP) n_pos = POS_URI;
                    else if (!is_token(c)) n_pos = POS_BAD;
                end
                POS_URI: begin
                    if (c == CH_SP) n_pos = POS_VER_H;
                    else if (is_control(c)) n_pos = POS_BAD;
                end
                POS_VER_H:  n_pos = (c == CH_H) ? POS_VER_T1 : POS_BAD;
                POS_VER_T1: n_pos = (c == CH_T) ? POS_VER_T2 : POS_BAD;
                POS_VER_T2: n_pos = (c == CH_T) ? POS_VER_P : POS_BAD;
                POS_VER_P:  n_pos = (c == CH_P) ? POS_VER_SLASH : POS_BAD;
                POS_VER_SLASH: begin
                    if (c == CH_SLASH) begin
                        n_major = '0;
                        n_minor = '0;
                        n_pos   = POS_MAJOR_START;
                    end else begin
                        n_pos = POS_BAD;
                    end
                end
                POS_MAJOR_START: begin
                    if (is_dec(c)) begin
                        n_major = add_digit(i_state.major, c);
                        n_pos   = POS_MAJOR;
                    end else begin
                        n_pos = POS_BAD;
                    end
                end
                POS_MAJOR: begin
                    if (c == CH_DOT) n_pos = POS_MINOR_START;
                    else if (is_dec(c)) n_major = add_digit(i_state.major, c);
                    else n_pos = POS_BAD;
                end
                POS_MINOR_START: begin
                    if (is_dec(c)) begin
                        n_minor = add_digit(i_state.minor, c);
                        n_pos   = POS_MINOR;
                    end else begin
                        n_pos = POS_BAD;
                    end
                end
                POS_MINOR: begin
                    if (c == CH_CR) n_pos = POS_NL1;
                    else if (is_dec(c)) n_minor = add_digit(i_state.minor, c);
                    else n_pos = POS_BAD;
                end
                POS_NL1: n_pos = (c == CH_LF) ? POS_LINE_START : POS_BAD;
                POS_LINE_START: begin
                    if (c == CH_CR) begin
                        n_pos = POS_NL3;
                    end else if (i_state.hdr_started && (c == CH_SP || c == CH_TAB)) begin
                        n_pos = POS_LWS;
                    end else if (is_token(c)) begin
                        n_hdr = 1'b1;
                        n_pos = POS_NAME;
                    end else begin
                        n_pos = POS_BAD;
                    end
                end
                POS_LWS: begin
                    if (c == CH_CR) n_pos = POS_NL2;
                    else if (c == CH_SP || c == CH_TAB) n_pos = POS_LWS;
                    else if (is_control(c)) n_pos = POS_BAD;
                    else n_pos = POS_VALUE;
                end
                POS_NAME: begin
                    if (c == CH_COLON) n_pos = POS_SPACE_VALUE;
                    else if (!is_token(c)) n_pos = POS_BAD;
                end
                POS_SPACE_VALUE: n_pos = (c == CH_SP) ? POS_VALUE : POS_BAD;
                POS_VALUE: begin
                    if (c == CH_CR) n_pos = POS_NL2;
                    else if (is_control(c)) n_pos = POS_BAD;
                end
                POS_NL2:  n_pos = (c == CH_LF) ? POS_LINE_START : POS_BAD;
                POS_NL3:  n_pos = (c == CH_LF) ? POS_GOOD : POS_BAD;
                POS_GOOD: n_pos = POS_GOOD;
                default:  n_pos = POS_BAD;
            endcase
        end
    end

    // Byte tag and verdict
    always_comb begin
        kind = KIND_NONE;
        if (!i_restart) begin
            unique case (i_state.pos)
                POS_METHOD_START: if (is_token(c)) kind = KIND_METHOD;
                POS_METHOD:       if (c != CH_SP && is_token(c)) kind = KIND_METHOD;
                POS_URI:          if (c != CH_SP && !is_control(c)) kind = KIND_URI;
                POS_LINE_START: begin
                    if (c != CH_CR
                        && !(i_state.hdr_started && (c == CH_SP || c == CH_TAB))
                        && is_token(c))
                        kind = KIND_NEW_NAME;
                end
                POS_LWS: begin
                    if (c != CH_CR && c != CH_SP && c != CH_TAB && !is_control(c))
                        kind = KIND_VALUE;
                end
                POS_NAME:  if (c != CH_COLON && is_token(c)) kind = KIND_NAME;
                POS_VALUE: if (c != CH_CR && !is_control(c)) kind = KIND_VALUE;
                default:   kind = KIND_NONE;
            endcase
        end
        verdict = VERDICT_MORE;
        if (!i_restart) begin
            if (n_pos == POS_BAD) verdict = VERDICT_BAD;
            else if (n_pos == POS_GOOD) verdict = VERDICT_GOOD;
        end
    end

    assign o_state.pos         = n_pos;
    assign o_state.hdr_started = n_hdr;
    assign o_state.major       = n_major;
    assign o_state.minor       = n_minor;

    assign o_result.verdict = verdict;
    assign o_result.kind    = kind;
    assign o_result.data    = (kind != KIND_NONE) ? c : 8'd0;

endmodule

/* rtl/core/http_request_head_parser_core.sv */
// Top level of the HTTP request head parser: input register, transition
// logic (hrhp_step) and result register. Depends on hrhp_pkg and hrhp_step.
//
//  Channel  Dir  tdata                                      tuser
//  s_axis   in   [7:0] in_byte                              [0] req_type
//  m_axis   out  [1:0] verdict, [9:2] out_byte,             [2:0] byte_kind
//                [17:10] version_major, [25:18] version_minor
//
// One beat per cycle sustained while the output is not stalled; each beat
// passes through the input register and then leaves from the result register.
// The parse state advances when a beat moves from the input register to
// the result register, so the parse position loop sets the rate.
// Synchronous active-low reset empties both registers and returns the parser
// to method start with versions cleared.
// A stalled output holds its beat; the input register takes a beat while it is
// empty or while the result register is free or being drained in the same cycle.
module http_request_head_parser_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] in_byte
    input  logic        i_s_axis_tuser,   // [0] req_type
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // [1:0] verdict, [9:2] out_byte,
                                          // [17:10] version_major,
                                          // [25:18] version_minor, rest zero
    output logic [2:0]  o_m_axis_tuser    // [2:0] byte_kind
);
    import hrhp_pkg::*;

    // Input register
    logic       r_in_valid;
    logic       r_in_restart;
    logic [7:0] r_in_byte;

    // Parser state
    t_state     r_state;
    t_state     n_state;
    t_result    w_result;

    // Result register
    logic       r_out_valid;
    t_result    r_out;
    logic [7:0] r_out_major;
    logic [7:0] r_out_minor;

    logic       w_adv;
    logic       w_take;

    // Move a beat forward when the result register is empty or being read
    assign w_adv  = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign w_take = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = !r_in_valid || w_adv;

    hrhp_step u_step (
        .i_state   (r_state),
        .i_restart (r_in_restart),
        .i_byte    (r_in_byte),
        .o_state   (n_state),
        .o_result  (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_take) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    // Capture payload on every accepted beat
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_in_restart <= i_s_axis_tuser;
            r_in_byte    <= i_s_axis_tdata;
        end
    end

    // Parser state commits only as a beat is handed to the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.pos         <= POS_METHOD_START;
            r_state.hdr_started <= 1'b0;
            r_state.major       <= '0;
            r_state.minor       <= '0;
        end else if (w_adv) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out       <= w_result;
            r_out_major <= n_state.major;
            r_out_minor <= n_state.minor;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'd0, r_out_minor, r_out_major, r_out.data, r_out.verdict};
    assign o_m_axis_tuser  = r_out.kind;

    // A tagged byte never comes with a final verdict
    a_kind_only_when_more: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser != KIND_NONE)
            |-> (o_m_axis_tdata[1:0] == VERDICT_MORE))
        else $error("tagged byte carries a final verdict");

    // Complete verdict is sticky until a restart beat
    a_good_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && !r_in_restart && r_state.pos == POS_GOOD)
            |=> (r_state.pos == POS_GOOD && r_out.verdict == VERDICT_GOOD))
        else $error("complete verdict lost without restart");

    // Restart beat clears versions and gives no tag
    a_restart_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_in_restart)
            |=> (o_m_axis_tdata[25:10] == 16'd0 && o_m_axis_tuser == KIND_NONE
                 && r_state.pos == POS_METHOD_START))
        else $error("restart did not clear parser");

    // Parser state only moves when a beat advances
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(r_state))
        else $error("parser state moved without a beat");

endmodule
